// ===== rtl/core/ibs_pkg.sv =====
package ibs_pkg;

  localparam int FIELD_W = 32;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_EXPAND = 2'd1,
    FN_MERGE  = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EXP_BEGIN,
    ST_SQ_START,
    ST_SQ_WAIT,
    ST_RR_START,
    ST_RR_WAIT,
    ST_CMP,
    ST_SQRT_START,
    ST_SQRT_WAIT,
    ST_SC_MUL_START,
    ST_SC_MUL_WAIT,
    ST_SC_DIV_START,
    ST_SC_DIV_WAIT,
    ST_APPLY,
    ST_MERGE_PTS,
    ST_EXP_END,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/ibs_in_if.sv =====
interface ibs_in_if import ibs_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic signed [FIELD_W-1:0] in_x;
  logic signed [FIELD_W-1:0] in_y;
  logic signed [FIELD_W-1:0] in_z;
  logic signed [FIELD_W-1:0] in_radius;

  modport source (output valid, func, in_x, in_y, in_z, in_radius, input ready);
  modport sink   (input valid, func, in_x, in_y, in_z, in_radius, output ready);
endinterface

// ===== rtl/core/ibs_out_if.sv =====
interface ibs_out_if import ibs_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] out_x;
  logic signed [FIELD_W-1:0] out_y;
  logic signed [FIELD_W-1:0] out_z;
  logic signed [FIELD_W-1:0] out_radius;
  logic                      is_empty;

  modport source (output valid, out_x, out_y, out_z, out_radius, is_empty, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_radius, is_empty, output ready);
endinterface

// ===== rtl/core/ibs_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module ibs_mul #(
  parameter int N = 33
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N-1:0]   a,
  input  logic [N-1:0]   b,
  output logic           done,
  output logic [2*N-1:0] p
);
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]   a_r;
  logic [2*N-1:0] acc_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [N:0]     sum_nxt;

  assign sum_nxt = {1'b0, acc_r[2*N-1:N]} + (acc_r[0] ? {1'b0, a_r} : {(N+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
        a_r    <= a;
        acc_r  <= {{N{1'b0}}, b};
      end else if (busy_r) begin
        acc_r <= {sum_nxt, acc_r[N-1:1]};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

// ===== rtl/core/ibs_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module ibs_sqrt #(
  parameter int N = 33
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*N-1:0] x,
  output logic           done,
  output logic [N-1:0]   root
);
  localparam int CW = $clog2(N + 1);

  logic [2*N-1:0] x_r;
  logic [N+1:0]   rem_r;
  logic [N-1:0]   root_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [N+3:0]   rem2;
  logic [N+3:0]   trial;
  logic [N+3:0]   diff;
  logic           ge;

  assign rem2  = {rem_r, x_r[2*N-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign diff  = rem2 - trial;
  assign ge    = (rem2 >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
        x_r    <= x;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        x_r    <= {x_r[2*N-3:0], 2'b00};
        rem_r  <= ge ? diff[N+1:0] : rem2[N+1:0];
        root_r <= {root_r[N-2:0], ge};
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// ===== rtl/core/ibs_div.sv =====
// Restoring divider, one quotient bit per cycle. Quotient must fit in N bits.
module ibs_div #(
  parameter int N = 33
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*N-1:0] n,
  input  logic [N-1:0]   d,
  output logic           done,
  output logic [N-1:0]   q
);
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  rem_r;
  logic [N-1:0]  low_r;
  logic [N-1:0]  d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [N:0]    rem2;
  logic [N:0]    diff;
  logic          ge;

  assign rem2 = {rem_r, low_r[N-1]};
  assign diff = rem2 - {1'b0, d_r};
  assign ge   = (rem2 >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
        rem_r  <= n[2*N-1:N];
        low_r  <= n[N-1:0];
        d_r    <= d;
      end else if (busy_r) begin
        rem_r <= ge ? diff[N-1:0] : rem2[N-1:0];
        low_r <= {low_r[N-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = low_r;
endmodule

// ===== rtl/core/incremental_bounding_sphere.sv =====
// One item in flight: the shared bit-serial multiplier, square root and divider
// units carry out the operations of each item one after another.
// Result sits in an output register; the next item is taken once it is loaded.
// Reset (synchronous, active low): center zero, radius -1.0 (empty), no result.
module incremental_bounding_sphere import ibs_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic       clk,
  input logic       rst_n,
  ibs_in_if.sink    in_bus,
  ibs_out_if.source out_bus
);
  localparam int W  = COORD_WIDTH;
  localparam int MW = W + 1;
  localparam int SW = W + 3;
  localparam int XW = ((W > FIELD_W) ? W : FIELD_W) + 1;
  localparam int EF = (FRAC_BITS < W - 1) ? FRAC_BITS : W - 1;

  localparam logic signed [W-1:0]  EMPTY_R = ~((W'(1) << EF) - W'(1));
  localparam logic signed [SW-1:0] SMAX    = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN    = ~SMAX;
  localparam logic signed [XW-1:0] XMAX    = (XW'(1) << (W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] XMIN    = ~XMAX;
  localparam logic signed [XW-1:0] OMAX    = (XW'(1) << (FIELD_W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] OMIN    = ~OMAX;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > SMAX) return SMAX[W-1:0];
    else if (v < SMIN) return SMIN[W-1:0];
    else return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_in(input logic signed [FIELD_W-1:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    if (e > XMAX) return XMAX[W-1:0];
    else if (e < XMIN) return XMIN[W-1:0];
    else return e[W-1:0];
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_out(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    e = XW'(v);
    if (e > OMAX) return OMAX[FIELD_W-1:0];
    else if (e < OMIN) return OMIN[FIELD_W-1:0];
    else return e[FIELD_W-1:0];
  endfunction

  state_t state_r, state_nxt;
  func_t  fn_r;

  logic signed [W-1:0]   o_r  [3];
  logic signed [W-1:0]   c_r  [3];
  logic signed [W-1:0]   t_r  [3];
  logic signed [W-1:0]   t2_r [3];
  logic signed [W+1:0]   scl_r[3];
  logic signed [W-1:0]   ro_r;
  logic signed [W-1:0]   cr_r;
  logic [2*MW-1:0]       acc_r;
  logic [MW-1:0]         len_r;
  logic [MW-1:0]         s_r;
  logic [1:0]            k_r;
  logic                  merge_r;
  logic                  pend2_r;

  logic                      out_valid_r;
  logic signed [FIELD_W-1:0] ox_r, oy_r, oz_r, orad_r;
  logic                      oemp_r;

  logic                mul_start, sqrt_start, div_start;
  logic                mul_done, sqrt_done, div_done;
  logic [MW-1:0]       mul_a, mul_b;
  logic [2*MW-1:0]     mul_p;
  logic [MW-1:0]       sqrt_root;
  logic [MW-1:0]       div_q;
  logic                out_load;

  logic signed [W:0]   dk;
  logic [MW-1:0]       dmag;
  logic                same_c;
  logic [MW-1:0]       gap;
  logic signed [W+1:0] qv;
  logic signed [W+1:0] sclv;

  // component difference for the lane being worked on
  assign dk     = {t_r[k_r][W-1], t_r[k_r]} - {c_r[k_r][W-1], c_r[k_r]};
  assign dmag   = dk[W] ? (~dk + 1'b1) : dk;
  assign same_c = (c_r[0] == o_r[0]) && (c_r[1] == o_r[1]) && (c_r[2] == o_r[2]);
  assign gap    = sqrt_root - {1'b0, cr_r};
  assign qv     = $signed({1'b0, div_q});
  assign sclv   = dk[W] ? -qv : qv;

  ibs_mul #(.N(MW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  ibs_sqrt #(.N(MW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .x(acc_r),
    .done(sqrt_done), .root(sqrt_root)
  );

  ibs_div #(.N(MW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .n(mul_p), .d(len_r),
    .done(div_done), .q(div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:         if (in_bus.valid) state_nxt = ST_DECODE;
      ST_DECODE: begin
        unique case (fn_r)
          FN_EXPAND: state_nxt = ST_EXP_BEGIN;
          FN_MERGE: begin
            if (ro_r[W-1] || cr_r[W-1] || same_c) state_nxt = ST_DONE;
            else state_nxt = ST_SQ_START;
          end
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_EXP_BEGIN:    state_nxt = cr_r[W-1] ? ST_EXP_END : ST_SQ_START;
      ST_SQ_START:     state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (mul_done) begin
          if (k_r == 2'd2) state_nxt = merge_r ? ST_SQRT_START : ST_RR_START;
          else state_nxt = ST_SQ_START;
        end
      end
      ST_RR_START:     state_nxt = ST_RR_WAIT;
      ST_RR_WAIT:      if (mul_done) state_nxt = ST_CMP;
      ST_CMP:          state_nxt = (acc_r <= mul_p) ? ST_EXP_END : ST_SQRT_START;
      ST_SQRT_START:   state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT:    if (sqrt_done) state_nxt = ST_SC_MUL_START;
      ST_SC_MUL_START: state_nxt = ST_SC_MUL_WAIT;
      ST_SC_MUL_WAIT:  if (mul_done) state_nxt = ST_SC_DIV_START;
      ST_SC_DIV_START: state_nxt = ST_SC_DIV_WAIT;
      ST_SC_DIV_WAIT: begin
        if (div_done) begin
          if (k_r == 2'd2) state_nxt = merge_r ? ST_MERGE_PTS : ST_APPLY;
          else state_nxt = ST_SC_MUL_START;
        end
      end
      ST_APPLY:        state_nxt = ST_EXP_END;
      ST_MERGE_PTS:    state_nxt = ST_EXP_BEGIN;
      ST_EXP_END:      state_nxt = pend2_r ? ST_EXP_BEGIN : ST_DONE;
      ST_DONE:         if (!out_valid_r || out_bus.ready) state_nxt = ST_IDLE;
      default:         state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start  = (state_r == ST_SQ_START) || (state_r == ST_RR_START) ||
                 (state_r == ST_SC_MUL_START);
    sqrt_start = (state_r == ST_SQRT_START);
    div_start  = (state_r == ST_SC_DIV_START);
    mul_a      = dmag;
    mul_b      = dmag;
    if (state_r == ST_RR_START) begin
      mul_a = {1'b0, cr_r};
      mul_b = {1'b0, cr_r};
    end else if (state_r == ST_SC_MUL_START) begin
      mul_b = s_r;
    end
    in_bus.ready = (state_r == ST_IDLE);
    out_load     = (state_r == ST_DONE) && (!out_valid_r || out_bus.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cr_r        <= EMPTY_R;
      merge_r     <= 1'b0;
      pend2_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) c_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_bus.valid) begin
            fn_r   <= func_t'(in_bus.func);
            o_r[0] <= sat_in(in_bus.in_x);
            o_r[1] <= sat_in(in_bus.in_y);
            o_r[2] <= sat_in(in_bus.in_z);
            ro_r   <= sat_in(in_bus.in_radius);
          end
        end
        ST_DECODE: begin
          unique case (fn_r)
            FN_CLEAR: begin
              for (int i = 0; i < 3; i++) c_r[i] <= '0;
              cr_r <= EMPTY_R;
            end
            FN_EXPAND: begin
              for (int i = 0; i < 3; i++) t_r[i] <= o_r[i];
              merge_r <= 1'b0;
              pend2_r <= 1'b0;
            end
            FN_MERGE: begin
              if (!ro_r[W-1]) begin
                if (cr_r[W-1]) begin
                  for (int i = 0; i < 3; i++) c_r[i] <= o_r[i];
                  cr_r <= ro_r;
                end else if (same_c) begin
                  if (ro_r > cr_r) cr_r <= ro_r;
                end else begin
                  for (int i = 0; i < 3; i++) t_r[i] <= o_r[i];
                  merge_r <= 1'b1;
                  pend2_r <= 1'b0;
                  k_r     <= 2'd0;
                  acc_r   <= '0;
                end
              end
            end
            default: ;
          endcase
        end
        ST_EXP_BEGIN: begin
          if (cr_r[W-1]) begin
            for (int i = 0; i < 3; i++) c_r[i] <= t_r[i];
            cr_r <= '0;
          end else begin
            k_r   <= 2'd0;
            acc_r <= '0;
          end
        end
        ST_SQ_WAIT: begin
          if (mul_done) begin
            acc_r <= acc_r + mul_p;
            k_r   <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          end
        end
        ST_SQRT_WAIT: begin
          if (sqrt_done) begin
            len_r <= sqrt_root;
            s_r   <= merge_r ? {1'b0, ro_r} : {1'b0, gap[MW-1:1]};
          end
        end
        ST_SC_DIV_WAIT: begin
          if (div_done) begin
            scl_r[k_r] <= sclv;
            k_r        <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          end
        end
        ST_APPLY: begin
          for (int i = 0; i < 3; i++) c_r[i] <= sat_w(SW'(c_r[i]) + SW'(scl_r[i]));
          cr_r <= sat_w(SW'(cr_r) + SW'($signed({1'b0, s_r})));
        end
        ST_MERGE_PTS: begin
          for (int i = 0; i < 3; i++) begin
            t_r[i]  <= sat_w(SW'(o_r[i]) + SW'(scl_r[i]));
            t2_r[i] <= sat_w(SW'(o_r[i]) - SW'(scl_r[i]));
          end
          merge_r <= 1'b0;
          pend2_r <= 1'b1;
        end
        ST_EXP_END: begin
          if (pend2_r) begin
            for (int i = 0; i < 3; i++) t_r[i] <= t2_r[i];
            pend2_r <= 1'b0;
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
        ox_r        <= sat_out(c_r[0]);
        oy_r        <= sat_out(c_r[1]);
        oz_r        <= sat_out(c_r[2]);
        orad_r      <= sat_out(cr_r);
        oemp_r      <= cr_r[W-1];
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.out_x      = ox_r;
  assign out_bus.out_y      = oy_r;
  assign out_bus.out_z      = oz_r;
  assign out_bus.out_radius = orad_r;
  assign out_bus.is_empty   = oemp_r;
endmodule

// ===== rtl/core/ibs_checker.sv =====
module ibs_checker import ibs_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [FIELD_W-1:0] out_radius,
  input logic                      is_empty
);
  // stalled beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == out_radius[FIELD_W-1]))
    else $error("is_empty disagrees with radius sign");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");
endmodule

bind incremental_bounding_sphere ibs_checker u_ibs_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_bus.valid),
  .in_ready(in_bus.ready),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_radius(out_bus.out_radius),
  .is_empty(out_bus.is_empty)
);

// ===== tb/tb_incremental_bounding_sphere.sv =====
module tb_incremental_bounding_sphere import ibs_pkg::*;;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] radius;
    logic               is_empty;
  } sphere_t;

  // running-sphere predictor, 32-bit Q16.16 with saturation
  class sphere_scoreboard;
    longint cx, cy, cz, cr;
    sphere_t pending[$];
    int mismatches;
    int results_seen;

    function new();
      cx = 0; cy = 0; cz = 0; cr = -65536;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function longint sat_c(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [127:0] sq_mag(longint v);
      logic [127:0] m;
      m = (v < 0) ? -v : v;
      return m * m;
    endfunction

    function logic [63:0] isqrt(logic [127:0] x);
      logic [63:0] res;
      logic [63:0] t;
      res = 0;
      for (int b = 63; b >= 0; b--) begin
        t = res | (64'd1 << b);
        if ({64'd0, t} * {64'd0, t} <= x) res = t;
      end
      return res;
    endfunction

    function longint scale_by(longint d, logic [63:0] s, logic [63:0] len);
      logic [127:0] m;
      logic [127:0] q;
      m = (d < 0) ? -d : d;
      q = (len == 0) ? 128'd0 : (m * s) / len;
      return (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function void grow(longint px, longint py, longint pz);
      longint dx, dy, dz;
      logic [127:0] l2;
      logic [63:0] len, delta, r;
      if (cr < 0) begin
        cx = px; cy = py; cz = pz; cr = 0;
        return;
      end
      r = cr;
      dx = px - cx; dy = py - cy; dz = pz - cz;
      l2 = sq_mag(dx) + sq_mag(dy) + sq_mag(dz);
      if (l2 <= {64'd0, r} * {64'd0, r}) return;
      len = isqrt(l2);
      delta = (len - r) >> 1;
      cx = sat_c(cx + scale_by(dx, delta, len));
      cy = sat_c(cy + scale_by(dy, delta, len));
      cz = sat_c(cz + scale_by(dz, delta, len));
      cr = sat_c(cr + longint'(delta));
    endfunction

    function void absorb(longint ox, longint oy, longint oz, longint ro);
      longint vx, vy, vz, wx, wy, wz;
      logic [63:0] len;
      if (ro < 0) return;
      if (cr < 0) begin
        cx = ox; cy = oy; cz = oz; cr = ro;
        return;
      end
      if (cx == ox && cy == oy && cz == oz) begin
        if (ro > cr) cr = ro;
        return;
      end
      vx = ox - cx; vy = oy - cy; vz = oz - cz;
      len = isqrt(sq_mag(vx) + sq_mag(vy) + sq_mag(vz));
      wx = scale_by(vx, ro, len);
      wy = scale_by(vy, ro, len);
      wz = scale_by(vz, ro, len);
      grow(sat_c(ox + wx), sat_c(oy + wy), sat_c(oz + wz));
      grow(sat_c(ox - wx), sat_c(oy - wy), sat_c(oz - wz));
    endfunction

    function void note_input(func_t f, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic signed [31:0] r);
      sphere_t s;
      case (f)
        FN_CLEAR: begin
          cx = 0; cy = 0; cz = 0; cr = -65536;
        end
        FN_EXPAND: grow(x, y, z);
        FN_MERGE:  absorb(x, y, z, r);
        default: ;
      endcase
      s.x = cx; s.y = cy; s.z = cz; s.radius = cr;
      s.is_empty = (cr < 0);
      pending.push_back(s);
    endfunction

    function void check_result(sphere_t got);
      sphere_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch #%0d: exp x=%0d y=%0d z=%0d r=%0d e=%0b",
                    " got x=%0d y=%0d z=%0d r=%0d e=%0b"},
                   results_seen, want.x, want.y, want.z, want.radius, want.is_empty,
                   got.x, got.y, got.z, got.radius, got.is_empty);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  ibs_in_if  in_bus();
  ibs_out_if out_bus();

  incremental_bounding_sphere i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  sphere_scoreboard sb = new();
  bit hold_off_req = 0;
  int hold_cycles = 0;
  int n_sent = 0;
  int n_func[4] = '{0, 0, 0, 0};

  initial begin
    in_bus.valid = 1'b0;
    in_bus.func = FN_CLEAR;
    in_bus.in_x = '0;
    in_bus.in_y = '0;
    in_bus.in_z = '0;
    in_bus.in_radius = '0;
    out_bus.ready = 1'b0;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  // (long enough to outlast two merges, so the block backs up)
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready)
        sb.check_result({out_bus.out_x, out_bus.out_y, out_bus.out_z,
                         out_bus.out_radius, out_bus.is_empty});
      if (hold_off_req && hold_cycles < 4000) begin
        hold_cycles <= hold_cycles + 1;
        out_bus.ready <= 1'b0;
      end else if (n_sent % 500 < 150) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(3) != 0);
      end
    end
  end

  task automatic send_beat(func_t f, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] r);
    in_bus.valid <= 1'b1;
    in_bus.func <= f;
    in_bus.in_x <= x;
    in_bus.in_y <= y;
    in_bus.in_z <= z;
    in_bus.in_radius <= r;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(f, x, y, z, r);
    n_sent++;
    n_func[f]++;
  endtask

  task automatic idle_gap(int cycles);
    in_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(3) == 0 ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(40 << 16)) - (20 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(7))
      0: return $urandom();
      1: return 32'h80000000 | $urandom();
      2: return 32'h7fffffff;
      default: return $urandom_range(8 << 16);
    endcase
  endfunction

  task automatic random_beat();
    int pick;
    func_t f;
    pick = $urandom_range(99);
    if (pick < 6) f = FN_CLEAR;
    else if (pick < 60) f = FN_EXPAND;
    else if (pick < 96) f = FN_MERGE;
    else f = FN_NOP;
    send_beat(f, rand_coord(), rand_coord(), rand_coord(), rand_radius());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty states, extremes, coincident centers, unused code
    send_beat(FN_EXPAND, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 0);
    send_beat(FN_EXPAND, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 0);
    send_beat(FN_EXPAND, 32'h0005_0000, 32'h0002_0000, 32'hfffd_0000, 0);
    send_beat(FN_MERGE, 32'h0003_0000, 32'h0002_0000, 32'hfffd_0000, 32'h0009_0000);
    send_beat(FN_MERGE, 32'h0003_0000, 32'h0002_0000, 32'hfffd_0000, 32'h0001_0000);
    send_beat(FN_MERGE, 32'h0, 32'h0, 32'h0, 32'hffff_ffff);
    send_beat(FN_MERGE, 32'h0010_0000, 32'h0, 32'h0, 32'h0002_0000);
    send_beat(FN_NOP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(FN_EXPAND, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_beat(FN_EXPAND, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_beat(FN_MERGE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(FN_CLEAR, 32'h1234_5678, 0, 0, 0);
    send_beat(FN_MERGE, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
    send_beat(FN_MERGE, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
    send_beat(FN_MERGE, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff);
    send_beat(FN_EXPAND, 32'h0, 32'h0, 32'h0, 0);
    send_beat(FN_CLEAR, 0, 0, 0, 0);
    send_beat(FN_MERGE, 32'h0001_8000, 32'hffff_0000, 32'h0, 32'h0);
    send_beat(FN_EXPAND, 32'h0001_8001, 32'hffff_0000, 32'h0, 0);

    // pause until drained
    idle_gap(1);
    while (sb.pending.size() != 0) @(posedge clk);

    // long receiver hold-off while items keep coming
    hold_off_req = 1'b1;
    repeat (20) random_beat();
    hold_off_req = 1'b0;

    while (n_sent < 2020) begin
      int burst;
      burst = $urandom_range(1, 30);
      if ($urandom_range(7) == 0) send_beat(FN_CLEAR, 0, 0, 0, 0);
      repeat (burst) random_beat();
      if ($urandom_range(2) != 0) idle_gap($urandom_range(1, 60));
    end
    idle_gap(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);

    $display("covered %0d beats: %0d clear, %0d expand, %0d merge, %0d unused code",
             n_sent, n_func[0], n_func[1], n_func[2], n_func[3]);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_incremental_bounding_sphere: done, clean");
    else
      $display("tb_incremental_bounding_sphere: done, errors");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_incremental_bounding_sphere: done, errors");
    $finish;
  end

endmodule
